>>> rtl/core/akr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akr_pkg
// Types, codes and the trigger key table shared by the key remapper files.
// ----------------------------------------------------------------------------
package akr_pkg;

    localparam int TYPE_W  = 5;
    localparam int CODE_W  = 10;
    localparam int VALUE_W = 32;

    localparam logic [TYPE_W-1:0] TYPE_SYNC = 5'd0;
    localparam logic [TYPE_W-1:0] TYPE_KEY  = 5'd1;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_PENDING = 2'd1;
    localparam logic [1:0] MODE_ALT     = 2'd2;
    localparam logic [1:0] MODE_CTRL    = 2'd3;

    localparam logic CFG_ALT_CODE  = 1'b0;
    localparam logic CFG_CTRL_CODE = 1'b1;

    localparam int NUM_TRIG = 12;
    localparam logic [CODE_W-1:0] TRIG_CODES [NUM_TRIG] = '{
        10'd30, 10'd46, 10'd13, 10'd18, 10'd20, 10'd22,
        10'd12, 10'd36, 10'd31, 10'd33, 10'd17, 10'd44
    };

    // Synthetic key events plus the optional passed-through event.
    typedef struct packed {
        logic [1:0]             syn_n;
        logic [1:0][CODE_W-1:0] syn_code;
        logic [1:0]             syn_val;
        logic                   pass;
        logic [TYPE_W-1:0]      event_type;
        logic [CODE_W-1:0]      event_code;
        logic signed [VALUE_W-1:0] event_value;
    } burst_t;

    function automatic logic is_trigger(input logic [CODE_W-1:0] code);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_TRIG; i++)
        begin
            if (TRIG_CODES[i] == code)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

>>> rtl/core/akr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akr_in_if / akr_out_if
// Valid/ready channels for incoming and emitted key events.
// ----------------------------------------------------------------------------
interface akr_in_if;
    logic               valid;
    logic               ready;
    logic [4:0]         event_type;
    logic [9:0]         event_code;
    logic signed [31:0] event_value;

    modport source (output valid, event_type, event_code, event_value, input ready);
    modport sink   (input valid, event_type, event_code, event_value, output ready);
endinterface

interface akr_out_if;
    logic               valid;
    logic               ready;
    logic [4:0]         out_type;
    logic [9:0]         out_code;
    logic signed [31:0] out_value;
    logic               last;

    modport source (output valid, out_type, out_code, out_value, last, input ready);
    modport sink   (input valid, out_type, out_code, out_value, last, output ready);
endinterface

>>> rtl/core/alt_to_ctrl_key_remapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_to_ctrl_key_remapper
// Remaps a held alt key to ctrl when a trigger key follows it.
// ----------------------------------------------------------------------------
// Latency: the first result of an event is shown the cycle after its transfer.
// Each event emits 2*k + p results (k synthetic keys, each a key event and a
// sync report, p = 1 if the event is passed on), at most 5, drained one at a
// time through the single output port from the burst register. The next event
// is taken in the cycle the last result of the current one is transferred.
// Reset: mode idle, alt code 56, ctrl code 29, output empty.
module alt_to_ctrl_key_remapper (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [9:0] cfg_wdata,
    akr_in_if.sink     evt_in,
    akr_out_if.source  evt_out
);
    import akr_pkg::*;

    logic [CODE_W-1:0] alt_code_reg;
    logic [CODE_W-1:0] ctrl_code_reg;
    burst_t            burst;
    logic              burst_nonempty;
    logic              free;
    logic              accept;

    assign evt_in.ready = free;
    assign accept       = evt_in.valid && free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alt_code_reg  <= 10'd56;
            ctrl_code_reg <= 10'd29;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALT_CODE:  alt_code_reg  <= cfg_wdata;
                CFG_CTRL_CODE: ctrl_code_reg <= cfg_wdata;
                default:       alt_code_reg  <= alt_code_reg;
            endcase
        end
    end

    akr_decode u_decode (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .event_type     (evt_in.event_type),
        .event_code     (evt_in.event_code),
        .event_value    (evt_in.event_value),
        .alt_code       (alt_code_reg),
        .ctrl_code      (ctrl_code_reg),
        .burst          (burst),
        .burst_nonempty (burst_nonempty)
    );

    akr_emit u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept && burst_nonempty),
        .burst   (burst),
        .free    (free),
        .evt_out (evt_out)
    );

endmodule

>>> rtl/core/akr_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akr_decode
// Holds the alt remap mode and turns one input event into a burst of events.
// ----------------------------------------------------------------------------
module akr_decode (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [akr_pkg::TYPE_W-1:0]   event_type,
    input  logic [akr_pkg::CODE_W-1:0]   event_code,
    input  logic signed [akr_pkg::VALUE_W-1:0] event_value,
    input  logic [akr_pkg::CODE_W-1:0]   alt_code,
    input  logic [akr_pkg::CODE_W-1:0]   ctrl_code,
    output akr_pkg::burst_t              burst,
    output logic                         burst_nonempty
);
    import akr_pkg::*;

    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic       is_alt;
    logic       press;
    logic       release_k;
    logic       trig;

    assign is_alt    = (event_code == alt_code);
    assign press     = is_alt && (event_value == 32'sd1 || event_value == 32'sd2);
    assign release_k = is_alt && (event_value == 32'sd0);
    assign trig      = is_trigger(event_code);

    always_comb
    begin
        mode_next         = mode_reg;
        burst             = '0;
        burst.pass        = 1'b1;
        burst.event_type  = event_type;
        burst.event_code  = event_code;
        burst.event_value = event_value;
        if (event_type == TYPE_KEY)
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (press)
                    begin
                        mode_next  = MODE_PENDING;
                        burst.pass = 1'b0;
                    end
                end
                MODE_PENDING:
                begin
                    if (press)
                    begin
                        burst.pass = 1'b0;
                    end
                    else if (release_k)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        burst.syn_n       = 2'd1;
                        burst.syn_code[0] = trig ? ctrl_code : alt_code;
                        burst.syn_val[0]  = 1'b1;
                        mode_next         = trig ? MODE_CTRL : MODE_ALT;
                    end
                end
                MODE_ALT:
                begin
                    if (press)
                    begin
                        burst.pass = 1'b0;
                    end
                    else if (release_k)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (trig)
                    begin
                        // release alt, then press ctrl
                        burst.syn_n       = 2'd2;
                        burst.syn_code[0] = alt_code;
                        burst.syn_val[0]  = 1'b0;
                        burst.syn_code[1] = ctrl_code;
                        burst.syn_val[1]  = 1'b1;
                        mode_next         = MODE_CTRL;
                    end
                end
                default:
                begin
                    if (press)
                    begin
                        burst.pass = 1'b0;
                    end
                    else if (release_k)
                    begin
                        burst.syn_n       = 2'd1;
                        burst.syn_code[0] = ctrl_code;
                        burst.syn_val[0]  = 1'b0;
                        burst.pass        = 1'b0;
                        mode_next         = MODE_IDLE;
                    end
                    else if (!trig)
                    begin
                        // drop ctrl and fall back to a real alt press
                        burst.syn_n       = 2'd2;
                        burst.syn_code[0] = ctrl_code;
                        burst.syn_val[0]  = 1'b0;
                        burst.syn_code[1] = alt_code;
                        burst.syn_val[1]  = 1'b1;
                        mode_next         = MODE_PENDING;
                    end
                end
            endcase
        end
    end

    assign burst_nonempty = burst.pass || (burst.syn_n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

>>> rtl/core/akr_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akr_emit
// Holds one burst and drains it as single events, one transfer per cycle while the output is ready.
// ----------------------------------------------------------------------------
module akr_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  akr_pkg::burst_t burst,
    output logic            free,
    akr_out_if.source       evt_out
);
    import akr_pkg::*;

    logic       busy_reg;
    logic       busy_next;
    burst_t     burst_reg;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic [2:0] total;
    logic [2:0] syn_len;
    logic       is_last;
    logic       take;
    logic       slot;

    assign syn_len = {burst_reg.syn_n, 1'b0};
    assign total   = syn_len + {2'b00, burst_reg.pass};
    assign is_last = (idx_reg == total - 3'd1);
    assign take    = busy_reg && evt_out.ready;
    assign free    = !busy_reg || (take && is_last);
    assign slot    = idx_reg[1];

    always_comb
    begin
        evt_out.valid = busy_reg;
        evt_out.last  = is_last;
        if (idx_reg < syn_len)
        begin
            if (!idx_reg[0])
            begin
                evt_out.out_type  = TYPE_KEY;
                evt_out.out_code  = burst_reg.syn_code[slot];
                evt_out.out_value = $signed({31'b0, burst_reg.syn_val[slot]});
            end
            else
            begin
                evt_out.out_type  = TYPE_SYNC;
                evt_out.out_code  = '0;
                evt_out.out_value = '0;
            end
        end
        else
        begin
            evt_out.out_type  = burst_reg.event_type;
            evt_out.out_code  = burst_reg.event_code;
            evt_out.out_value = burst_reg.event_value;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (free)
        begin
            busy_next = load;
            idx_next  = '0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            burst_reg <= burst;
        end
    end

endmodule

>>> rtl/core/akr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akr_checker
// Port-level checks on the key remapper output stream.
// ----------------------------------------------------------------------------
module akr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  out_type,
    input logic [9:0]  out_code,
    input logic [31:0] out_value,
    input logic        out_last
);
    import akr_pkg::*;

    // hold a stalled transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_type)
            && $stable(out_code) && $stable(out_value) && $stable(out_last))
        else $error("stalled output changed");

    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> out_type == TYPE_KEY || out_type == TYPE_SYNC)
        else $error("synthetic event of wrong type");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last && out_type == TYPE_SYNC |-> out_code == '0 && out_value == '0)
        else $error("synthetic sync report not zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("input taken mid-burst");

endmodule

bind alt_to_ctrl_key_remapper akr_checker u_akr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (evt_in.ready),
    .out_valid (evt_out.valid),
    .out_ready (evt_out.ready),
    .out_type  (evt_out.out_type),
    .out_code  (evt_out.out_code),
    .out_value (evt_out.out_value),
    .out_last  (evt_out.last)
);
